>>> sv/brta_pkg.sv
// Shared types, constants and codes for the boot region table allocator.
`timescale 1ns / 1ps
package brta_pkg;

    localparam int ADDR_W           = 48;
    localparam int REGION_SLOTS_DEF = 32;
    localparam int PAGE_SHIFT_DEF   = 12;
    localparam int TOTAL_W          = 6;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_ALLOC   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_NOFIT   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic              reserved;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              hit;
        logic              overlap;
        logic              below;
        logic [ADDR_W-1:0] region_end;
    } eval_t;

endpackage

>>> sv/brta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module brta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/brta_eval.sv
// Shared compare unit: checks one table entry against the current request.
`timescale 1ns / 1ps
module brta_eval import brta_pkg::*; (
    input  logic [1:0]        op,
    input  entry_t            entry,
    input  logic [ADDR_W-1:0] req_base,
    input  logic [ADDR_W-1:0] req_end,
    input  logic [ADDR_W-1:0] req_size,
    input  logic [ADDR_W:0]   floor,
    output eval_t             res
);

    logic [ADDR_W-1:0] t;

    assign t = entry.start + entry.length;

    always_comb
    begin
        res.region_end = t;
        res.overlap    = (req_base < t) && (entry.start < req_end);
        res.below      = entry.start < req_base;
        unique case (op)
            OP_RESERVE: res.hit = !entry.reserved && (entry.start <= req_base)
                                  && (req_end <= t);
            OP_ALLOC:   res.hit = !entry.reserved && ({1'b0, entry.start} >= floor)
                                  && (entry.length >= req_size);
            default:    res.hit = 1'b0;
        endcase
    end

endmodule

>>> sv/boot_region_table_allocator.sv
// Top level: sequencer, region table RAM and result register of the allocator.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------
//   in       | in_valid / in_stall      | operation, base, size
//   out      | out_valid / out_stall    | status, address, region_total
//   config   | cfg_write                | cfg_data (alloc_floor)
//
// A transaction scans the entries through the single RAM read port (a read
// state, then an evaluate state per entry), moves entries for a slot open or
// close (a read state, then a write state per entry) and ends with up to three
// entry writes. A range error or a full table on add goes from idle to done.
// The table needs no clearing after reset; only slots below the count are read.
// in_stall is high while a transaction is in work; a result still stalled in the
// output register holds the next transaction in its last cycle.
`timescale 1ns / 1ps
module boot_region_table_allocator import brta_pkg::*; #(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    parameter int PAGE_SHIFT   = PAGE_SHIFT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [ADDR_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [ADDR_W-1:0]  base,
    input  logic [ADDR_W-1:0]  size,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [ADDR_W-1:0]  address,
    output logic [TOTAL_W-1:0] region_total
);

    localparam int IW = $clog2(REGION_SLOTS);
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(REGION_SLOTS);
    localparam logic [ADDR_W:0] PAGE_LOW =
        {{(ADDR_W + 1 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_EV = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_SH_RD   = 4'd4;
    localparam logic [3:0] S_SH_WR   = 4'd5;
    localparam logic [3:0] S_PUT     = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0]        state_reg;
    logic [1:0]        op_reg;
    logic [ADDR_W-1:0] b_reg, sz_reg, e_reg;
    logic [ADDR_W:0]   floor_reg;
    logic [CW-1:0]     count_reg, j_reg, pos_reg, hit_reg;
    logic              found_reg;
    entry_t            cur_reg, prev_reg;
    logic [ADDR_W-1:0] cur_end_reg, prev_end_reg;
    logic              sh_open_reg;
    logic [1:0]        sh_k_reg;
    logic [CW-1:0]     sh_j_reg, sh_last_reg;
    logic [1:0]        put_n_reg, put_ptr_reg;
    logic [CW-1:0]     put_idx_reg [3];
    entry_t            put_ent_reg [3];
    logic [1:0]        st_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [TOTAL_W-1:0] total_reg;

    // request alignment
    logic [ADDR_W-1:0] b_al;
    logic [ADDR_W:0]   sz_al;
    logic              range_ok, alloc_ok;

    assign b_al     = base & ~PAGE_LOW[ADDR_W-1:0];
    assign sz_al    = ({1'b0, size} + PAGE_LOW) & ~PAGE_LOW;
    assign range_ok = (sz_al != '0) && (sz_al <= {1'b0, ~b_al});
    assign alloc_ok = (sz_al != '0) && !sz_al[ADDR_W];

    // RAM and compare unit
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;
    eval_t             ev;
    logic [CW-1:0]     sh_dst;

    assign ram_rdata = entry_t'(ram_rbits);
    assign sh_dst = sh_open_reg ? sh_j_reg + CW'(sh_k_reg) : sh_j_reg - CW'(1);

    brta_ram #(.WIDTH(ENTRY_W), .DEPTH(REGION_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    brta_eval u_eval (
        .op       (op_reg),
        .entry    (ram_rdata),
        .req_base (b_reg),
        .req_end  (e_reg),
        .req_size (sz_reg),
        .floor    (floor_reg),
        .res      (ev)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = put_idx_reg[put_ptr_reg][IW-1:0];
        ram_wdata = put_ent_reg[put_ptr_reg];
        ram_raddr = j_reg[IW-1:0];
        unique case (state_reg)
            S_SH_RD: ram_raddr = sh_j_reg[IW-1:0];
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sh_dst[IW-1:0];
                ram_wdata = ram_rdata;
            end
            S_PUT:   ram_we = 1'b1;
            default: ;
        endcase
    end

    // decision from the scan result
    logic [1:0]        d_st;
    logic              d_shift, d_open;
    logic [1:0]        d_k, d_putn;
    logic [CW-1:0]     d_at, d_cnt;
    logic [CW-1:0]     d_idx [3];
    entry_t            d_ent [3];
    logic [1:0]        need;
    logic              grow;

    always_comb
    begin
        d_st    = ST_OK;
        d_shift = 1'b0;
        d_open  = 1'b1;
        d_k     = 2'd1;
        d_putn  = 2'd0;
        d_at    = hit_reg;
        d_cnt   = count_reg;
        for (int n = 0; n < 3; n++)
        begin
            d_idx[n] = hit_reg + CW'(n);
            d_ent[n] = '0;
        end
        need = 2'(b_reg > cur_reg.start) + 2'(e_reg < cur_end_reg);
        grow = (hit_reg != '0) && prev_reg.reserved && (prev_end_reg == cur_reg.start);
        unique case (op_reg)
            OP_ADD:
            begin
                d_shift  = 1'b1;
                d_at     = pos_reg;
                d_putn   = 2'd1;
                d_idx[0] = pos_reg;
                d_ent[0] = '{b_reg, sz_reg, 1'b0};
                d_cnt    = count_reg + CW'(1);
            end
            OP_RESERVE:
            begin
                priority if (!found_reg)
                    d_st = ST_NOMATCH;
                else if ({1'b0, count_reg} + (CW+1)'(need) > {1'b0, SLOTS})
                    d_st = ST_FULL;
                else if (need == 2'd0)
                begin
                    d_putn   = 2'd1;
                    d_ent[0] = '{cur_reg.start, cur_reg.length, 1'b1};
                end
                else if (b_reg == cur_reg.start)
                begin
                    d_shift  = 1'b1;
                    d_putn   = 2'd2;
                    d_ent[0] = '{b_reg, sz_reg, 1'b1};
                    d_ent[1] = '{e_reg, cur_end_reg - e_reg, 1'b0};
                    d_cnt    = count_reg + CW'(1);
                end
                else if (e_reg == cur_end_reg)
                begin
                    d_shift  = 1'b1;
                    d_putn   = 2'd2;
                    d_ent[0] = '{cur_reg.start, b_reg - cur_reg.start, 1'b0};
                    d_ent[1] = '{b_reg, sz_reg, 1'b1};
                    d_cnt    = count_reg + CW'(1);
                end
                else
                begin
                    d_shift  = 1'b1;
                    d_k      = 2'd2;
                    d_putn   = 2'd3;
                    d_ent[0] = '{cur_reg.start, b_reg - cur_reg.start, 1'b0};
                    d_ent[1] = '{b_reg, sz_reg, 1'b1};
                    d_ent[2] = '{e_reg, cur_end_reg - e_reg, 1'b0};
                    d_cnt    = count_reg + CW'(2);
                end
            end
            OP_ALLOC:
            begin
                priority if (!found_reg)
                    d_st = ST_NOFIT;
                else if (grow)
                begin
                    d_putn   = 2'd1;
                    d_idx[0] = hit_reg - CW'(1);
                    d_ent[0] = '{prev_reg.start, prev_reg.length + sz_reg, 1'b1};
                    if (cur_reg.length == sz_reg)
                    begin
                        d_shift = 1'b1;
                        d_open  = 1'b0;
                        d_cnt   = count_reg - CW'(1);
                    end
                    else
                    begin
                        d_putn   = 2'd2;
                        d_idx[1] = hit_reg;
                        d_ent[1] = '{cur_reg.start + sz_reg, cur_reg.length - sz_reg, 1'b0};
                    end
                end
                else if (cur_reg.length == sz_reg)
                begin
                    d_putn   = 2'd1;
                    d_ent[0] = '{cur_reg.start, cur_reg.length, 1'b1};
                end
                else if (count_reg >= SLOTS)
                    d_st = ST_FULL;
                else
                begin
                    d_shift  = 1'b1;
                    d_putn   = 2'd2;
                    d_ent[0] = '{cur_reg.start, sz_reg, 1'b1};
                    d_ent[1] = '{cur_reg.start + sz_reg, cur_reg.length - sz_reg, 1'b0};
                    d_cnt    = count_reg + CW'(1);
                end
            end
            default: d_st = ST_NOMATCH;
        endcase
    end

    logic [CW+TOTAL_W-1:0] count_wide;
    assign count_wide = {{TOTAL_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            floor_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                floor_reg <= ({1'b0, cfg_data} + PAGE_LOW) & ~PAGE_LOW;
            end
            // drop the result once taken, unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= operation;
                        b_reg     <= b_al;
                        sz_reg    <= sz_al[ADDR_W-1:0];
                        e_reg     <= b_al + sz_al[ADDR_W-1:0];
                        j_reg     <= '0;
                        pos_reg   <= '0;
                        found_reg <= 1'b0;
                        hit_reg   <= '0;
                        addr_reg  <= '0;
                        priority if (operation == OP_ADD && !range_ok)
                        begin
                            st_reg    <= ST_NOMATCH;
                            state_reg <= S_DONE;
                        end
                        else if (operation == OP_ADD && count_reg >= SLOTS)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else if (operation == OP_RESERVE && !range_ok)
                        begin
                            st_reg    <= ST_NOMATCH;
                            state_reg <= S_DONE;
                        end
                        else if (operation == OP_ALLOC && !alloc_ok)
                        begin
                            st_reg    <= ST_NOFIT;
                            state_reg <= S_DONE;
                        end
                        else if (operation != OP_ADD && operation != OP_RESERVE
                                 && operation != OP_ALLOC)
                        begin
                            st_reg    <= ST_NOMATCH;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            st_reg    <= ST_OK;
                            state_reg <= (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_EV;
                S_SCAN_EV:
                begin
                    if (op_reg == OP_ADD && ev.overlap)
                    begin
                        st_reg    <= ST_NOMATCH;
                        state_reg <= S_DONE;
                    end
                    else if (ev.hit)
                    begin
                        found_reg   <= 1'b1;
                        hit_reg     <= j_reg;
                        cur_reg     <= ram_rdata;
                        cur_end_reg <= ev.region_end;
                        state_reg   <= S_DECIDE;
                    end
                    else
                    begin
                        // keep the predecessor for the grow check
                        prev_reg     <= ram_rdata;
                        prev_end_reg <= ev.region_end;
                        if (ev.below)
                        begin
                            pos_reg <= j_reg + CW'(1);
                        end
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= (j_reg + CW'(1) == count_reg) ? S_DECIDE : S_SCAN_RD;
                    end
                end
                S_DECIDE:
                begin
                    st_reg      <= d_st;
                    addr_reg    <= (d_st == ST_OK && op_reg == OP_ALLOC) ? cur_reg.start : '0;
                    put_n_reg   <= d_putn;
                    put_ptr_reg <= 2'd0;
                    for (int n = 0; n < 3; n++)
                    begin
                        put_idx_reg[n] <= d_idx[n];
                        put_ent_reg[n] <= d_ent[n];
                    end
                    sh_open_reg <= d_open;
                    sh_k_reg    <= d_k;
                    if (d_st != ST_OK)
                        state_reg <= S_DONE;
                    else
                    begin
                        count_reg <= d_cnt;
                        priority if (d_shift && d_open && count_reg > d_at)
                        begin
                            sh_j_reg    <= count_reg - CW'(1);
                            sh_last_reg <= d_at;
                            state_reg   <= S_SH_RD;
                        end
                        else if (d_shift && !d_open && d_at + CW'(1) < count_reg)
                        begin
                            sh_j_reg    <= d_at + CW'(1);
                            sh_last_reg <= count_reg - CW'(1);
                            state_reg   <= S_SH_RD;
                        end
                        else
                            state_reg <= (d_putn != 2'd0) ? S_PUT : S_DONE;
                    end
                end
                S_SH_RD: state_reg <= S_SH_WR;
                S_SH_WR:
                begin
                    if (sh_j_reg == sh_last_reg)
                        state_reg <= (put_n_reg != 2'd0) ? S_PUT : S_DONE;
                    else
                    begin
                        sh_j_reg  <= sh_open_reg ? sh_j_reg - CW'(1) : sh_j_reg + CW'(1);
                        state_reg <= S_SH_RD;
                    end
                end
                S_PUT:
                begin
                    put_ptr_reg <= put_ptr_reg + 2'd1;
                    if (put_ptr_reg + 2'd1 == put_n_reg)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        address_reg   <= addr_reg;
                        total_reg     <= count_wide[TOTAL_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign address      = address_reg;
    assign region_total = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS)
        else $error("region count above slot count");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (address == '0))
        else $error("address nonzero on failed transaction");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> $stable(count_reg))
        else $error("region count changed while idle");

endmodule

>>> verif/boot_region_table_allocator_tb.sv
// Self-checking testbench for the boot region table allocator.
`timescale 1ns / 1ps
module boot_region_table_allocator_tb;
    import brta_pkg::*;

    localparam int          SLOTS     = REGION_SLOTS_DEF;
    localparam logic [63:0] PAGE_LOW  = 64'hFFF;
    localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF;
    localparam int          PHASE_LEN = 325;
    localparam int          DRAIN_CYC = 300;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [ADDR_W-1:0]  cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  size;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  address;
    logic [TOTAL_W-1:0] region_total;

    boot_region_table_allocator uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .base(base), .size(size), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .address(address), .region_total(region_total)
    );

    typedef struct packed {
        logic [1:0]         st;
        logic [ADDR_W-1:0]  addr;
        logic [TOTAL_W-1:0] total;
    } outcome_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [ADDR_W-1:0]  b;
        logic [ADDR_W-1:0]  s;
        logic               typed;
        logic [1:0]         st;
        logic [TOTAL_W-1:0] total;
    } row_t;

    // table shadow
    logic [63:0] tbl_start [SLOTS];
    logic [63:0] tbl_len   [SLOTS];
    logic        tbl_rsv   [SLOTS];
    int          tbl_count;
    logic [63:0] floor_reg;

    outcome_t pending_results[$];
    int       errors;
    bit       hold_req;

    function automatic void open_slot(input int at);
        int i;
        if (tbl_count >= SLOTS) return;
        for (i = tbl_count; i > at; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_len[i]   = tbl_len[i-1];
            tbl_rsv[i]   = tbl_rsv[i-1];
        end
        tbl_count++;
    endfunction

    function automatic void put(input int i, input logic [63:0] s, input logic [63:0] l,
                                input logic r);
        if (i >= SLOTS) return;
        tbl_start[i] = s;
        tbl_len[i]   = l;
        tbl_rsv[i]   = r;
    endfunction

    function automatic outcome_t apply_request(input logic [1:0] op,
                                               input logic [ADDR_W-1:0] base_in,
                                               input logic [ADDR_W-1:0] size_in);
        logic [63:0] b, sz, e, s, t, len, fl;
        logic [1:0]  st;
        logic [63:0] addr;
        int          i, j, pos, need;
        bit          range_ok, done;
        outcome_t    o;
        b    = {16'd0, base_in} & ~PAGE_LOW;
        sz   = ({16'd0, size_in} + PAGE_LOW) & ~PAGE_LOW;
        addr = 0;
        done = 0;
        range_ok = (sz != 0) && (sz <= ADDR_MASK - b);
        e = b + sz;
        case (op)
            OP_ADD: begin
                if (!range_ok) st = ST_NOMATCH;
                else if (tbl_count >= SLOTS) st = ST_FULL;
                else begin
                    st  = ST_OK;
                    pos = 0;
                    for (i = 0; i < tbl_count; i++) begin
                        s = tbl_start[i];
                        t = s + tbl_len[i];
                        if (b < t && s < e) st = ST_NOMATCH;
                        if (s < b) pos = i + 1;
                    end
                    if (st == ST_OK) begin
                        open_slot(pos);
                        put(pos, b, sz, 1'b0);
                    end
                end
            end
            OP_RESERVE: begin
                st = ST_NOMATCH;
                if (range_ok) begin
                    for (i = 0; i < tbl_count && !done; i++) begin
                        s = tbl_start[i];
                        t = s + tbl_len[i];
                        if (!tbl_rsv[i] && s <= b && e <= t) begin
                            done = 1;
                            need = int'(b > s) + int'(e < t);
                            if (tbl_count + need > SLOTS) st = ST_FULL;
                            else begin
                                st = ST_OK;
                                if (need == 0) tbl_rsv[i] = 1'b1;
                                else if (b == s) begin
                                    open_slot(i);
                                    put(i, b, sz, 1'b1);
                                    put(i + 1, e, t - e, 1'b0);
                                end else if (e == t) begin
                                    open_slot(i);
                                    put(i, s, b - s, 1'b0);
                                    put(i + 1, b, sz, 1'b1);
                                end else begin
                                    open_slot(i);
                                    open_slot(i);
                                    put(i, s, b - s, 1'b0);
                                    put(i + 1, b, sz, 1'b1);
                                    put(i + 2, e, t - e, 1'b0);
                                end
                            end
                        end
                    end
                end
            end
            OP_ALLOC: begin
                st = ST_NOFIT;
                if (sz != 0 && sz <= ADDR_MASK) begin
                    fl = (floor_reg + PAGE_LOW) & ~PAGE_LOW;
                    for (i = 0; i < tbl_count && !done; i++) begin
                        s   = tbl_start[i];
                        len = tbl_len[i];
                        if (!tbl_rsv[i] && s >= fl && len >= sz) begin
                            done = 1;
                            st   = ST_OK;
                            if (i > 0 && tbl_rsv[i-1] && tbl_start[i-1] + tbl_len[i-1] == s)
                            begin
                                // grow the reserved neighbor, drop the free one if emptied
                                tbl_len[i-1] = tbl_len[i-1] + sz;
                                tbl_start[i] = s + sz;
                                tbl_len[i]   = len - sz;
                                if (tbl_len[i] == 0) begin
                                    for (j = i; j + 1 < tbl_count; j++) begin
                                        tbl_start[j] = tbl_start[j+1];
                                        tbl_len[j]   = tbl_len[j+1];
                                        tbl_rsv[j]   = tbl_rsv[j+1];
                                    end
                                    tbl_count--;
                                end
                            end else if (len == sz) tbl_rsv[i] = 1'b1;
                            else if (tbl_count >= SLOTS) st = ST_FULL;
                            else begin
                                open_slot(i);
                                put(i, s, sz, 1'b1);
                                put(i + 1, s + sz, len - sz, 1'b0);
                            end
                            if (st == ST_OK) addr = s;
                        end
                    end
                end
            end
            default: st = ST_NOMATCH;
        endcase
        o.st    = st;
        o.addr  = addr[ADDR_W-1:0];
        o.total = tbl_count[TOTAL_W-1:0];
        return o;
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // result checker
    always @(posedge clk) begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction st=%0d addr=%h total=%0d",
                         $time, status, address, region_total);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    errors++;
                end
                if (address !== want.addr) begin
                    $display("%0t: address expected %h actual %h", $time, want.addr, address);
                    errors++;
                end
                if (region_total !== want.total) begin
                    $display("%0t: region_total expected %0d actual %0d",
                             $time, want.total, region_total);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int run;
        int pick;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 0;
                out_stall <= 1'b0;
                repeat (50) @(posedge clk);
            end else begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 20);
                end else if (pick < 92) begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run - 1) @(posedge clk);
            end
        end
    end

    // offer one transaction starting at the current edge; keep valid high if more follow and no gap is drawn
    task automatic send(input logic [1:0] op, input logic [ADDR_W-1:0] b,
                        input logic [ADDR_W-1:0] s, input bit typed,
                        input logic [1:0] t_st, input logic [TOTAL_W-1:0] t_total,
                        input bit last);
        outcome_t o;
        int       gap;
        int       pick;
        operation <= op;
        base      <= b;
        size      <= s;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        o = apply_request(op, b, s);
        if (typed) begin
            o.st    = t_st;
            o.addr  = '0;
            o.total = t_total;
        end
        pending_results.push_back(o);
        pick = $urandom_range(99);
        if (pick < 45) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 4);
        else gap = $urandom_range(20, 60);
        if (last || gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pick_item(output logic [1:0] op, output logic [ADDR_W-1:0] b,
                             output logic [ADDR_W-1:0] s);
        int          pick, n, k, pages, off, l;
        int          free_idx[$];
        logic [63:0] hi;
        pick = $urandom_range(99);
        op   = OP_ALLOC;
        b    = ADDR_W'({$urandom, $urandom});
        s    = ADDR_W'(($urandom_range(1, 8) << 12) - $urandom_range(0, 4095));
        if (pick < 10) begin
            op = 2'($urandom_range(0, 3));
            s  = ADDR_W'({$urandom, $urandom});
        end else if (pick < 35) begin
            op = OP_ADD;
            hi = ($urandom_range(0, 9) == 0) ? 64'h8000_0000_0000 : 64'd0;
            b  = ADDR_W'(hi + (64'($urandom_range(0, 255)) << 16)
                        + (64'($urandom_range(0, 15)) << 12) + $urandom_range(0, 4095));
            s  = ADDR_W'(($urandom_range(1, 24) << 12) - $urandom_range(0, 4095));
        end else if (pick < 68) begin
            op = OP_RESERVE;
            for (k = 0; k < tbl_count; k++)
                if (!tbl_rsv[k]) free_idx.push_back(k);
            n = free_idx.size();
            if (n > 0) begin
                k     = free_idx[$urandom_range(0, n - 1)];
                pages = (tbl_len[k] >> 12) > 64 ? 64 : int'(tbl_len[k] >> 12);
                off   = $urandom_range(0, pages - 1);
                l     = $urandom_range(1, pages - off);
                b     = ADDR_W'(tbl_start[k] + (64'(off) << 12) + $urandom_range(0, 4095));
                s     = ADDR_W'((64'(l) << 12) - $urandom_range(0, 4095));
            end else begin
                b = ADDR_W'(64'($urandom_range(0, 255)) << 16);
            end
        end
    endtask

    task automatic write_floor(input logic [ADDR_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        floor_reg = {16'd0, v};
        @(posedge clk);
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    row_t directed[$];
    logic [ADDR_W-1:0] floors[6];

    initial begin
        logic [1:0]        op;
        logic [ADDR_W-1:0] b, s;
        int                p, i;
        errors    = 0;
        hold_req  = 0;
        tbl_count = 0;
        floor_reg = 0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = '0;
        base      = '0;
        size      = '0;

        //            op          base                 size               typed st   total
        directed = '{
            '{OP_ADD,     48'h0,               48'h0,             1, ST_NOMATCH, 6'd0},
            '{OP_ALLOC,   48'h0,               48'h0,             1, ST_NOFIT,   6'd0},
            '{2'd3,       48'hFFFF_FFFF_FFFF,  48'hFFFF_FFFF_FFFF, 1, ST_NOMATCH, 6'd0},
            '{OP_ADD,     48'hFFFF_FFFF_FFFF,  48'hFFFF_FFFF_FFFF, 1, ST_NOMATCH, 6'd0},
            '{OP_ALLOC,   48'h0,               48'hFFFF_FFFF_FFFF, 1, ST_NOFIT,   6'd0},
            '{OP_RESERVE, 48'h10000,           48'h1000,          1, ST_NOMATCH, 6'd0},
            '{OP_ALLOC,   48'h0,               48'h1000,          1, ST_NOFIT,   6'd0},
            '{OP_ADD,     48'h10000,           48'h10000,         1, ST_OK,      6'd1},
            '{OP_ADD,     48'h18000,           48'h1000,          1, ST_NOMATCH, 6'd1},
            '{OP_ADD,     48'hFFFF_FFFF_F000,  48'h1000,          0, 2'd0,       6'd0},
            '{OP_ADD,     48'hFFFF_FFFF_EFFF,  48'h1,             0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h10000,           48'h1000,          0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h1F123,           48'h1,             0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h14000,           48'h2000,          0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h14000,           48'h1000,          0, 2'd0,       6'd0},
            '{OP_ALLOC,   48'h0,               48'h2001,          0, 2'd0,       6'd0},
            '{OP_ALLOC,   48'h0,               48'h1000,          0, 2'd0,       6'd0},
            '{OP_ADD,     48'h100FFF,          48'h2001,          0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h100000,          48'h3000,          0, 2'd0,       6'd0},
            '{OP_ADD,     48'h200000,          48'h4000,          0, 2'd0,       6'd0},
            '{OP_ALLOC,   48'h0,               48'h4000,          0, 2'd0,       6'd0},
            '{OP_ALLOC,   48'h0,               48'h10000,         0, 2'd0,       6'd0},
            '{OP_RESERVE, 48'h300000,          48'h1000,          0, 2'd0,       6'd0}
        };
        floors = '{48'h0, 48'h0040_0800, 48'hFFFF_FFFF_FFFF, ADDR_W'({$urandom, $urandom}),
                   48'h7FF, 48'h0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed.size(); i++)
            send(directed[i].op, directed[i].b, directed[i].s, directed[i].typed,
                 directed[i].st, directed[i].total, i == directed.size() - 1);
        settle();

        for (p = 0; p < 6; p++) begin
            write_floor(floors[p]);
            if (p == 0) hold_req = 1;
            for (i = 0; i < PHASE_LEN; i++) begin
                pick_item(op, b, s);
                send(op, b, s, 0, 2'd0, 6'd0, i == PHASE_LEN - 1);
            end
            settle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/brta_pkg.sv
sv/brta_ram.sv
sv/brta_eval.sv
sv/boot_region_table_allocator.sv
verif/boot_region_table_allocator_tb.sv
